// File: rtl/svbd_pkg.sv
// Shared types and constants of the servo bus status deframer.
// Used by the front parser, the reply queue, the result emitter and the top level.
`default_nettype none

package svbd_pkg;

  localparam int MAX_PACKET_DEF = 64;
  localparam int IDX_W          = 6;
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    FN_BYTE    = 2'd0,
    FN_TIMEOUT = 2'd1,
    FN_ARM     = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_UNARMED = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         dev_id;
    logic [7:0]         err_bits;
    logic [IDX_W-1:0]   count;
  } desc_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [7:0]         data;
  } mem_wr_t;

endpackage

`default_nettype wire

// File: rtl/servo_bus_status_deframer.sv
// Servo bus status deframer, top level: stream ports, packing and checks.
// Instantiates svbd_front, svbd_queue and svbd_back; uses svbd_pkg.
//
// Input beats carry a selector in in_tuser: a received byte, a reply
// timeout or an arm with the expected device id. After an arm, bytes are
// parsed as 0xFF 0xFF, id, length, error, parameters and inverted-sum checksum.
// A good reply yields one result beat per parameter byte (one beat if none),
// marked by out_tlast on its final beat; a bad reply, timeout or unarmed
// timeout yields one beat with the status in out_tuser.
// The first result beat of a reply passes through the reply queue and then
// the output register; later beats follow one per cycle while out_tready is high.
// Throughput: one input beat per cycle. Parameter bytes of a new reply wait
// while the previous reply's parameters are still being read out of the
// single parameter memory; the two-entry reply queue holds the front back
// only when full.
// Reset clears the parser (unarmed, hunting the header) and empties the
// queue and output register; the parameter memory is not cleared.
// When out_tready is low the output beat holds and the queue fills, after
// which in_tready drops.
`default_nettype none

module servo_bus_status_deframer
  import svbd_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // rx_byte[7:0], target_id[15:8]
  input  wire logic [1:0]   in_tuser,   // func[1:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // device_id[7:0], error_bits[15:8],
                                        // param_index[21:16], param_byte[29:22]
  output logic [2:0]        out_tuser,  // status[1:0], param_valid[2]
  output logic              out_tlast
);

  logic              q_push, q_pop, q_full, q_empty, mem_release;
  desc_t             push_desc, q_head;
  mem_wr_t           mem_wr;
  status_t           o_status;
  logic [7:0]        o_dev_id, o_err_bits, o_param_byte;
  logic              o_param_valid;
  logic [IDX_W-1:0]  o_param_index;

  svbd_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .func        (in_tuser),
    .rx_byte     (in_tdata[7:0]),
    .target_id   (in_tdata[15:8]),
    .q_full      (q_full),
    .push        (q_push),
    .push_desc   (push_desc),
    .mem_wr      (mem_wr),
    .mem_release (mem_release)
  );

  svbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  svbd_back #(.MAX_PACKET(MAX_PACKET)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mem_wr          (mem_wr),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .mem_release     (mem_release),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (o_status),
    .out_dev_id      (o_dev_id),
    .out_err_bits    (o_err_bits),
    .out_param_valid (o_param_valid),
    .out_param_index (o_param_index),
    .out_param_byte  (o_param_byte),
    .out_last        (out_tlast)
  );

  assign out_tdata = {2'b00, o_param_byte, o_param_index, o_err_bits, o_dev_id};
  assign out_tuser = {o_param_valid, o_status};

  a_param_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_param_valid |-> o_status == ST_OK)
    else $error("parameter beat with non-ok status");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_status != ST_OK |-> out_tlast && !o_param_valid)
    else $error("failure reply not a single last beat");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("reply queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("reply queue underflow");

endmodule

`default_nettype wire

// File: rtl/svbd_front.sv
// Front parser: accepts input beats, tracks the packet phase and checksum,
// writes parameter bytes to the emitter memory and queues one reply record. Uses svbd_pkg.
`default_nettype none

module svbd_front
  import svbd_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  target_id,
  input  wire logic        q_full,
  output logic             push,
  output desc_t            push_desc,
  output mem_wr_t          mem_wr,
  input  wire logic        mem_release
);

  localparam logic [8:0] LEN_MAX = 9'(MAX_PACKET - 4);

  typedef enum logic [2:0] {
    PH_HUNT1, PH_HUNT2, PH_ID, PH_LEN, PH_ERR, PH_PARAM, PH_CSUM
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              armed_r, armed_nxt;
  logic              got_any_r, got_any_nxt;
  logic              lock_r, lock_nxt;
  logic [7:0]        exp_id_r, exp_id_nxt;
  logic [7:0]        length_r, length_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        err_r, err_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              accept;

  assign in_ready = !q_full && !(lock_r && phase_r == PH_PARAM);
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt   = phase_r;
    armed_nxt   = armed_r;
    got_any_nxt = got_any_r;
    exp_id_nxt  = exp_id_r;
    length_nxt  = length_r;
    sum_nxt     = sum_r;
    err_nxt     = err_r;
    cnt_nxt     = cnt_r;
    push        = 1'b0;
    push_desc   = '0;
    mem_wr      = '0;
    if (accept) begin
      case (func_t'(func))
        FN_ARM: begin
          armed_nxt   = 1'b1;
          exp_id_nxt  = target_id;
          phase_nxt   = PH_HUNT1;
          length_nxt  = '0;
          cnt_nxt     = '0;
          sum_nxt     = '0;
          err_nxt     = '0;
          got_any_nxt = 1'b0;
        end
        FN_TIMEOUT: begin
          push = 1'b1;
          if (!armed_r) begin
            push_desc.status = ST_UNARMED;
          end else begin
            push_desc.status = got_any_r ? ST_CORRUPT : ST_TIMEOUT;
          end
          armed_nxt   = 1'b0;
          phase_nxt   = PH_HUNT1;
          length_nxt  = '0;
          cnt_nxt     = '0;
          sum_nxt     = '0;
          err_nxt     = '0;
          got_any_nxt = 1'b0;
        end
        FN_BYTE: begin
          if (armed_r) begin
            got_any_nxt = 1'b1;
            unique case (phase_r)
              PH_HUNT1: begin
                if (rx_byte == HDR_BYTE) phase_nxt = PH_HUNT2;
              end
              PH_HUNT2: begin
                phase_nxt = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
              end
              PH_ID: begin
                if (rx_byte != exp_id_r) begin
                  phase_nxt = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
                end else begin
                  sum_nxt   = rx_byte;
                  phase_nxt = PH_LEN;
                end
              end
              PH_LEN: begin
                if (rx_byte < 8'd2 || {1'b0, rx_byte} > LEN_MAX) begin
                  push             = 1'b1;
                  push_desc.status = ST_CORRUPT;
                  armed_nxt        = 1'b0;
                  phase_nxt        = PH_HUNT1;
                  length_nxt       = '0;
                  cnt_nxt          = '0;
                  sum_nxt          = '0;
                  err_nxt          = '0;
                  got_any_nxt      = 1'b0;
                end else begin
                  length_nxt = rx_byte;
                  sum_nxt    = sum_r + rx_byte;
                  phase_nxt  = PH_ERR;
                end
              end
              PH_ERR: begin
                err_nxt   = rx_byte;
                sum_nxt   = sum_r + rx_byte;
                cnt_nxt   = '0;
                phase_nxt = (length_r > 8'd2) ? PH_PARAM : PH_CSUM;
              end
              PH_PARAM: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = cnt_r;
                mem_wr.data = rx_byte;
                cnt_nxt     = cnt_r + 1'b1;
                sum_nxt     = sum_r + rx_byte;
                if ({1'b0, cnt_r} + 7'd1 >= 7'(length_r - 8'd2)) phase_nxt = PH_CSUM;
              end
              PH_CSUM: begin
                push = 1'b1;
                if (rx_byte == ~sum_r) begin
                  push_desc.status   = ST_OK;
                  push_desc.dev_id   = exp_id_r;
                  push_desc.err_bits = err_r;
                  push_desc.count    = cnt_r;
                end else begin
                  push_desc.status = ST_CORRUPT;
                end
                armed_nxt   = 1'b0;
                phase_nxt   = PH_HUNT1;
                length_nxt  = '0;
                cnt_nxt     = '0;
                sum_nxt     = '0;
                err_nxt     = '0;
                got_any_nxt = 1'b0;
              end
              default: phase_nxt = PH_HUNT1;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    lock_nxt = lock_r;
    if (mem_release) lock_nxt = 1'b0;
    if (push && push_desc.count != '0) lock_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT1;
      armed_r   <= 1'b0;
      got_any_r <= 1'b0;
      lock_r    <= 1'b0;
      exp_id_r  <= '0;
      length_r  <= '0;
      sum_r     <= '0;
      err_r     <= '0;
      cnt_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      armed_r   <= armed_nxt;
      got_any_r <= got_any_nxt;
      lock_r    <= lock_nxt;
      exp_id_r  <= exp_id_nxt;
      length_r  <= length_nxt;
      sum_r     <= sum_nxt;
      err_r     <= err_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/svbd_queue.sv
// Two-entry queue of reply records between the front parser and the emitter.
// Uses svbd_pkg for the record type.
`default_nettype none

module svbd_queue
  import svbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output desc_t      head,
  output logic       full,
  output logic       empty
);

  desc_t       ent_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/svbd_back.sv
// Result emitter: holds the parameter memory, expands each reply record into
// result beats and drives the registered output channel. Uses svbd_pkg.
`default_nettype none

module svbd_back
  import svbd_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mem_wr_t            mem_wr,
  input  wire logic               q_empty,
  input  wire desc_t              q_head,
  output logic                    q_pop,
  output logic                    mem_release,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output status_t                 out_status,
  output logic [7:0]              out_dev_id,
  output logic [7:0]              out_err_bits,
  output logic                    out_param_valid,
  output logic [IDX_W-1:0]        out_param_index,
  output logic [7:0]              out_param_byte,
  output logic                    out_last
);

  localparam int DEPTH = (MAX_PACKET - 6 > 2) ? MAX_PACKET - 6 : 2;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]        mem_r [DEPTH];
  logic [7:0]        rd_r;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              valid_r, valid_nxt;
  status_t           status_r;
  logic [7:0]        dev_id_r, err_r;
  logic              pv_r;
  logic [IDX_W-1:0]  idx_r;
  logic              last_r;
  logic              issue, beat_last, has_params;

  assign has_params  = (q_head.count != '0);
  assign issue       = !q_empty && (!valid_r || out_ready);
  assign beat_last   = !has_params || (k_r == q_head.count - 1'b1);
  assign q_pop       = issue && beat_last;
  assign mem_release = q_pop && has_params;

  always_comb begin
    k_nxt = k_r;
    if (issue) k_nxt = beat_last ? '0 : k_r + 1'b1;
    valid_nxt = valid_r;
    if (issue) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) mem_r[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    if (issue) rd_r <= mem_r[k_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      status_r <= q_head.status;
      dev_id_r <= q_head.dev_id;
      err_r    <= q_head.err_bits;
      pv_r     <= has_params;
      idx_r    <= has_params ? k_r : '0;
      last_r   <= beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_dev_id      = dev_id_r;
  assign out_err_bits    = err_r;
  assign out_param_valid = pv_r;
  assign out_param_index = idx_r;
  assign out_param_byte  = pv_r ? rd_r : 8'd0;
  assign out_last        = last_r;

endmodule

`default_nettype wire
